/* hw/rtl/ggenc_pkg.sv */
// Shared types and constants for the Golomb gap encoder.
`default_nettype none

package ggenc_pkg;

   // Fixed field widths
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned DIV_W       = 31;
   localparam int unsigned CHUNK_W     = 32;
   localparam int unsigned COUNT_W     = 6;
   localparam int unsigned TLEN_W      = 6;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned UNARY_W     = 12;
   localparam int unsigned BOUND_W     = DIV_W + UNARY_W;

   // Unary run limits: 64 chunks of 32 bits less room for a full tail
   localparam int unsigned MAX_UNARY_BITS = 1984;
   localparam int unsigned UNARY_CAP      = 2016;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register file
   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;

   typedef enum logic [0:0] {
      REG_GOLOMB_DIVISOR = 1'b0
   } reg_index_type;

   typedef enum logic {
      MODE_HEADER = 1'b0,
      MODE_GAP    = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [CHUNK_W-1:0]   code_bits;
      logic [COUNT_W-1:0]   bit_count;
      logic                 last_chunk;
      logic                 error;
   } rsp_type;

   // One coded item: a unary run of ones followed by a tail pattern
   typedef struct packed {
      logic                 error;
      logic [UNARY_W-1:0]   unary;
      logic [CHUNK_W-1:0]   tail;
      logic [TLEN_W-1:0]    tail_len;
   } job_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_CLASSIFY,
      FR_DIVIDE,
      FR_FINISH,
      FR_PUSH
   } front_state_type;

endpackage

`default_nettype wire

/* hw/rtl/golomb_gap_encoder_top.sv */
// Top level of the Golomb gap encoder: register port, front, queue and back.
// Flow: header and rejected items go from classify straight to the queue; gap items
//   pass a restoring divider first, one quotient bit per step. The front takes no
//   new item until the last is pushed. The back sends one chunk per cycle once an
//   item is loaded, unless rsp_ready stalls it; a full queue stalls the front.
// Reset: synchronous, active high; clears control state and sets the divisor to 1.
`default_nettype none

module golomb_gap_encoder_top #(
   parameter int unsigned MAX_UNARY_BITS = ggenc_pkg::MAX_UNARY_BITS
) (
   input  var logic                            clock,
   input  var logic                            reset,
   input  var logic                            req_valid,
   output var logic                            req_ready,
   input  var ggenc_pkg::req_type              req_data,
   output var logic                            rsp_valid,
   input  var logic                            rsp_ready,
   output var ggenc_pkg::rsp_type              rsp_data,
   input  var logic                            psel,
   input  var logic                            penable,
   input  var logic                            pwrite,
   input  var logic [ggenc_pkg::PADDR_W-1:0]   paddr,
   input  var logic [ggenc_pkg::PDATA_W-1:0]   pwdata,
   output var logic [ggenc_pkg::PDATA_W-1:0]   prdata,
   output var logic                            pready
);

   logic [ggenc_pkg::DIV_W-1:0] divisor_ff, divisor_in;
   ggenc_pkg::reg_index_type    reg_index;
   logic                        csr_write;

   ggenc_pkg::job_type          push_job;
   ggenc_pkg::job_type          pop_job;
   logic                        job_push;
   logic                        job_pop;
   logic                        queue_full;
   logic                        queue_empty;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = ggenc_pkg::reg_index_type'(paddr[ggenc_pkg::PADDR_W-1]);

   always_comb begin
      divisor_in = divisor_ff;
      prdata     = '0;
      case (reg_index)
         ggenc_pkg::REG_GOLOMB_DIVISOR: begin
            prdata = ggenc_pkg::PDATA_W'(divisor_ff);
            if (csr_write) begin
               divisor_in = pwdata[ggenc_pkg::DIV_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= ggenc_pkg::DIV_W'(1);
      end else begin
         divisor_ff <= divisor_in;
      end
   end

   ggenc_front #(
      .MAX_UNARY_BITS (MAX_UNARY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .divisor    (divisor_ff),
      .job_push   (job_push),
      .job_data   (push_job),
      .queue_full (queue_full)
   );

   ggenc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (queue_empty)
   );

   ggenc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_data    (pop_job),
      .queue_empty (queue_empty),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/ggenc_queue.sv */
// Small register FIFO carrying coded jobs from the front to the back.
`default_nettype none

module ggenc_queue (
   input  var logic               clock,
   input  var logic               reset,
   input  var logic               push,
   input  var ggenc_pkg::job_type push_data,
   output var logic               full,
   input  var logic               pop,
   output var ggenc_pkg::job_type pop_data,
   output var logic               empty
);

   localparam int unsigned PTR_W = $clog2(ggenc_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(ggenc_pkg::QUEUE_DEPTH + 1);

   ggenc_pkg::job_type entry_ff [ggenc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(ggenc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ggenc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ggenc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ggenc_front.sv */
// Front end: accepts items, checks them, divides gaps and builds coded jobs.
`default_nettype none

module ggenc_front #(
   parameter int unsigned MAX_UNARY_BITS = ggenc_pkg::MAX_UNARY_BITS
) (
   input  var logic                         clock,
   input  var logic                         reset,
   input  var logic                         req_valid,
   output var logic                         req_ready,
   input  var ggenc_pkg::req_type           req_data,
   input  var logic [ggenc_pkg::DIV_W-1:0]  divisor,
   output var logic                         job_push,
   output var ggenc_pkg::job_type           job_data,
   input  var logic                         queue_full
);

   localparam int unsigned LIMIT  = (MAX_UNARY_BITS < ggenc_pkg::UNARY_CAP) ?
                                    MAX_UNARY_BITS : ggenc_pkg::UNARY_CAP;
   localparam int unsigned QUO_W  = $clog2(LIMIT + 1);
   localparam int unsigned STEP_W = $clog2(QUO_W);
   localparam int unsigned VW     = ggenc_pkg::VALUE_W;
   localparam int unsigned BW     = ggenc_pkg::BOUND_W;

   ggenc_pkg::front_state_type state_ff, state_in;

   // Divisor-derived values, refreshed every cycle
   logic [ggenc_pkg::DIV_W-1:0]   b_ff, b_in;
   logic                          one_ff, one_in;
   logic [ggenc_pkg::SHIFT_W-1:0] n_ff, n_in;
   logic [VW-1:0]                 g_ff, g_in;
   logic [BW-1:0]                 bound_ff, bound_in;
   logic [ggenc_pkg::DIV_W-1:0]   b_minus1;

   // Item and divider registers
   ggenc_pkg::mode_type           mode_ff, mode_in;
   logic [VW-1:0]                 value_ff, value_in;
   logic [VW-1:0]                 rem_ff, rem_in;
   logic [QUO_W-1:0]              quo_ff, quo_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   ggenc_pkg::job_type            job_ff, job_in;

   // Combinational helpers
   logic [VW-1:0]                 value_m1;
   logic [ggenc_pkg::SHIFT_W-1:0] expo;
   logic [BW-1:0]                 trial;
   logic                          trial_ok;

   assign req_ready = (state_ff == ggenc_pkg::FR_IDLE);
   assign job_push  = (state_ff == ggenc_pkg::FR_PUSH) && !queue_full;
   assign job_data  = job_ff;

   // Divisor preprocessing: effective b, n = ceil(log2 b), g = 2^n - b, overflow bound
   always_comb begin
      b_in     = (divisor == '0) ? ggenc_pkg::DIV_W'(1) : divisor;
      one_in   = (b_in == ggenc_pkg::DIV_W'(1));
      b_minus1 = b_in - 1'b1;
      n_in     = '0;
      for (int i = 0; i < ggenc_pkg::DIV_W; i++) begin
         if (b_minus1[i]) begin
            n_in = ggenc_pkg::SHIFT_W'(i + 1);
         end
      end
      g_in     = (VW'(1) << n_in) - VW'(b_in);
      bound_in = BW'(b_in) * BW'(LIMIT + 1);
   end

   // Exponent of a header value
   always_comb begin
      expo = '0;
      for (int i = 1; i < VW; i++) begin
         if (value_ff[i]) begin
            expo = ggenc_pkg::SHIFT_W'(i);
         end
      end
   end

   // One restoring division step
   assign value_m1 = value_ff - 1'b1;
   assign trial    = BW'(b_ff) << step_ff;
   assign trial_ok = (BW'(rem_ff) >= trial);

   // Next state and datapath
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      value_in = value_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      case (state_ff)
         ggenc_pkg::FR_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               value_in = req_data.value;
               state_in = ggenc_pkg::FR_CLASSIFY;
            end
         end
         ggenc_pkg::FR_CLASSIFY: begin
            job_in = '0;
            if (value_ff == '0) begin
               job_in.error = 1'b1;
               state_in     = ggenc_pkg::FR_PUSH;
            end else if (mode_ff == ggenc_pkg::MODE_HEADER) begin
               // Gamma: e ones, then a zero and the e low bits
               job_in.unary    = ggenc_pkg::UNARY_W'(expo);
               job_in.tail     = value_ff & ((VW'(1) << expo) - 1'b1);
               job_in.tail_len = ggenc_pkg::TLEN_W'(expo) + 1'b1;
               state_in        = ggenc_pkg::FR_PUSH;
            end else if (BW'(value_m1) >= bound_ff) begin
               // Quotient above the unary limit
               job_in.error = 1'b1;
               state_in     = ggenc_pkg::FR_PUSH;
            end else begin
               rem_in   = value_m1;
               quo_in   = '0;
               step_in  = STEP_W'(QUO_W - 1);
               state_in = ggenc_pkg::FR_DIVIDE;
            end
         end
         ggenc_pkg::FR_DIVIDE: begin
            if (trial_ok) begin
               rem_in = rem_ff - trial[VW-1:0];
            end
            quo_in = {quo_ff[QUO_W-2:0], trial_ok};
            if (step_ff == '0) begin
               state_in = ggenc_pkg::FR_FINISH;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ggenc_pkg::FR_FINISH: begin
            // Truncated binary remainder, closing zero of the run included
            job_in       = '0;
            job_in.unary = ggenc_pkg::UNARY_W'(quo_ff);
            if (one_ff) begin
               job_in.tail_len = ggenc_pkg::TLEN_W'(1);
            end else if (rem_ff < g_ff) begin
               job_in.tail     = rem_ff;
               job_in.tail_len = ggenc_pkg::TLEN_W'(n_ff);
            end else begin
               job_in.tail     = rem_ff + g_ff;
               job_in.tail_len = ggenc_pkg::TLEN_W'(n_ff) + 1'b1;
            end
            state_in = ggenc_pkg::FR_PUSH;
         end
         ggenc_pkg::FR_PUSH: begin
            if (!queue_full) begin
               state_in = ggenc_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = ggenc_pkg::FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ggenc_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff     <= b_in;
      one_ff   <= one_in;
      n_ff     <= n_in;
      g_ff     <= g_in;
      bound_ff <= bound_in;
      mode_ff  <= mode_in;
      value_ff <= value_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      job_ff   <= job_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/ggenc_back.sv */
// Back end: splits each coded job into 32-bit chunks behind an output register.
`default_nettype none

module ggenc_back (
   input  var logic               clock,
   input  var logic               reset,
   input  var ggenc_pkg::job_type job_data,
   input  var logic               queue_empty,
   output var logic               job_pop,
   output var logic               rsp_valid,
   input  var logic               rsp_ready,
   output var ggenc_pkg::rsp_type rsp_data
);

   localparam int unsigned CW = ggenc_pkg::CHUNK_W;
   localparam int unsigned UW = ggenc_pkg::UNARY_W;
   localparam int unsigned TW = ggenc_pkg::TLEN_W;
   localparam int unsigned SW = ggenc_pkg::SHIFT_W;

   logic                 busy_ff, busy_in;
   logic                 err_ff, err_in;
   logic [UW-1:0]        ones_ff, ones_in;
   logic [CW-1:0]        tail_ff, tail_in;
   logic [TW-1:0]        tlen_ff, tlen_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ggenc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic                 emit;
   logic [SW-1:0]        run_len;
   logic [2*CW-1:0]      packed_bits;
   logic [TW:0]          total;
   logic [TW:0]          excess;
   logic [SW-1:0]        shamt;
   ggenc_pkg::rsp_type   chunk;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = busy_ff && out_free;
   assign job_pop   = !busy_ff && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Short run of ones glued to the remaining tail
   assign run_len     = ones_ff[SW-1:0];
   assign packed_bits = ((((2*CW)'(1)) << run_len) - 1'b1) << tlen_ff | (2*CW)'(tail_ff);
   assign total       = (TW+1)'(run_len) + (TW+1)'(tlen_ff);
   assign excess      = total - (TW+1)'(CW);
   assign shamt       = excess[SW-1:0];

   // Chunk selection and working state update
   always_comb begin
      chunk   = '0;
      busy_in = busy_ff;
      err_in  = err_ff;
      ones_in = ones_ff;
      tail_in = tail_ff;
      tlen_in = tlen_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         err_in  = job_data.error;
         ones_in = job_data.unary;
         tail_in = job_data.tail;
         tlen_in = job_data.tail_len;
      end else if (emit) begin
         if (err_ff) begin
            chunk.last_chunk = 1'b1;
            chunk.error      = 1'b1;
            busy_in          = 1'b0;
         end else if (ones_ff >= UW'(CW)) begin
            // Full chunk of ones; the tail always follows
            chunk.code_bits = '1;
            chunk.bit_count = ggenc_pkg::COUNT_W'(CW);
            ones_in         = ones_ff - UW'(CW);
         end else if (total <= (TW+1)'(CW)) begin
            chunk.code_bits  = packed_bits[CW-1:0];
            chunk.bit_count  = ggenc_pkg::COUNT_W'(total);
            chunk.last_chunk = 1'b1;
            busy_in          = 1'b0;
         end else begin
            // Take the top 32 bits, keep the low tail bits
            chunk.code_bits = CW'(packed_bits >> shamt);
            chunk.bit_count = ggenc_pkg::COUNT_W'(CW);
            ones_in         = '0;
            tail_in         = tail_ff & ((CW'(1) << shamt) - 1'b1);
            tlen_in         = TW'(shamt);
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chunk;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      ones_ff     <= ones_in;
      tail_ff     <= tail_in;
      tlen_ff     <= tlen_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/ggenc_checker.sv */
// Port-level checks for the Golomb gap encoder, bound to the top level.
`default_nettype none

module ggenc_checker (
   input var logic               clock,
   input var logic               reset,
   input var logic               rsp_valid,
   input var logic               rsp_ready,
   input var ggenc_pkg::rsp_type rsp_data
);

   // Error beats carry no code and close the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.bit_count == '0 && rsp_data.last_chunk)
      else $error("error beat with code bits or not last");

   // Every beat but the last of an item is a full chunk
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_chunk |->
         rsp_data.bit_count == ggenc_pkg::COUNT_W'(ggenc_pkg::CHUNK_W) && !rsp_data.error)
      else $error("non-final chunk not full");

   // A coded beat holds between 1 and 32 bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.error |->
         rsp_data.bit_count != '0 &&
         rsp_data.bit_count <= ggenc_pkg::COUNT_W'(ggenc_pkg::CHUNK_W))
      else $error("coded beat with bad bit count");

   // A stalled beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

endmodule

bind golomb_gap_encoder_top ggenc_checker u_ggenc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* test/golomb_gap_encoder_checker.sv */
// Checker for the Golomb gap encoder: predicts code chunks and compares result beats.
module golomb_gap_encoder_checker
   import ggenc_pkg::*;
(
   input  var logic                  clock,
   input  var logic                  reset,
   input  var logic                  req_valid,
   input  var logic                  req_ready,
   input  var req_type               req_data,
   input  var logic                  rsp_valid,
   input  var logic                  rsp_ready,
   input  var rsp_type               rsp_data,
   input  var logic                  psel,
   input  var logic                  penable,
   input  var logic                  pwrite,
   input  var logic [PADDR_W-1:0]    paddr,
   input  var logic [PDATA_W-1:0]    pwdata,
   input  var logic [PDATA_W-1:0]    prdata,
   input  var logic                  pready,
   output var int unsigned           miss_count,
   output var int unsigned           chunks_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [PADDR_W-1:0] DIVISOR_ADDR = {REG_GOLOMB_DIVISOR, 2'b00};
   localparam int unsigned CW        = CHUNK_W;
   localparam int unsigned MAX_CHUNKS = 64;
   // longest unary run: room for 64 chunks less a full tail, capped by the counter
   localparam int unsigned ROOM_CAP  = MAX_CHUNKS * CW - 32;
   localparam int unsigned RUN_CAP0  = (MAX_UNARY_BITS < ROOM_CAP) ? MAX_UNARY_BITS : ROOM_CAP;
   localparam int unsigned RUN_LIMIT = (RUN_CAP0 > 4095) ? 4095 : RUN_CAP0;

   logic [DIV_W-1:0] divisor;
   rsp_type          owed_chunks[$];
   rsp_type          want;

   function automatic void push_chunk(input logic [31:0] bits, input int unsigned cnt,
                                      input logic last, input logic err);
      rsp_type c;
      c.code_bits  = bits;
      c.bit_count  = cnt[COUNT_W-1:0];
      c.last_chunk = last;
      c.error      = err;
      owed_chunks.push_back(c);
   endfunction

   // Expected chunks for one input beat: unary run of ones, then the tail pattern
   function automatic void predict_code(input req_type item);
      logic [63:0] v, b, q, r, g, tail;
      int unsigned run, tlen, n, cnt, k;
      logic [31:0] acc;
      logic        bitv, full;
      v = {32'd0, item.value};
      if (v == 0) begin
         push_chunk(32'd0, 0, 1'b1, 1'b1);
         return;
      end
      if (item.mode == MODE_HEADER) begin
         // Elias gamma: e ones, then a zero and the e low bits
         n = 0;
         while ((v >> (n + 1)) != 0) n++;
         run  = n;
         tail = v & ((64'd1 << n) - 64'd1);
         tlen = n + 1;
      end else begin
         b = {33'd0, divisor};
         if (b == 0) b = 1;
         q = (v - 1) / b;
         r = (v - 1) - q * b;
         if (q > RUN_LIMIT) begin
            push_chunk(32'd0, 0, 1'b1, 1'b1);
            return;
         end
         n = 0;
         while ((64'd1 << n) < b) n++;
         g   = (64'd1 << n) - b;
         run = q[31:0];
         // tail carries the closing zero of the unary run
         if (b == 1) begin
            tail = 0;
            tlen = 1;
         end else if (r < g) begin
            tail = r;
            tlen = n;
         end else begin
            tail = r + g;
            tlen = n + 1;
         end
      end
      acc  = '0;
      cnt  = 0;
      k    = 0;
      full = 1'b0;
      while (!full && (run != 0 || tlen != 0)) begin
         if (run != 0) begin
            bitv = 1'b1;
            run--;
         end else begin
            tlen--;
            bitv = tail[tlen];
         end
         if (cnt == CW) begin
            if (k >= MAX_CHUNKS - 1) begin
               full = 1'b1;
            end else begin
               push_chunk(acc, cnt, 1'b0, 1'b0);
               k++;
               acc = '0;
               cnt = 0;
            end
         end
         if (!full) begin
            acc = {acc[30:0], bitv};
            cnt++;
         end
      end
      push_chunk(acc, cnt, 1'b1, 1'b0);
   endfunction

   task automatic report_miss(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
      $display("%0t ns: %s got %h, wanted %h", $time, what, got, exp_val);
      miss_count++;
   endtask

   // Watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         divisor = 31'd1;
         owed_chunks.delete();
      end else begin
         // result beat against the oldest expected chunk
         if (rsp_valid && rsp_ready) begin
            if (owed_chunks.size() == 0) begin
               report_miss("unexpected result beat", rsp_data.code_bits, 32'd0);
            end else begin
               want = owed_chunks.pop_front();
               if (rsp_data.code_bits != want.code_bits)
                  report_miss("code_bits", rsp_data.code_bits, want.code_bits);
               if (rsp_data.bit_count != want.bit_count)
                  report_miss("bit_count", 32'(rsp_data.bit_count), 32'(want.bit_count));
               if (rsp_data.last_chunk != want.last_chunk)
                  report_miss("last_chunk", 32'(rsp_data.last_chunk), 32'(want.last_chunk));
               if (rsp_data.error != want.error)
                  report_miss("error", 32'(rsp_data.error), 32'(want.error));
            end
         end
         if (req_valid && req_ready)
            predict_code(req_data);
         // register port: track writes, check reads
         if (psel && penable && pready && paddr == DIVISOR_ADDR) begin
            if (pwrite)
               divisor = pwdata[DIV_W-1:0];
            else if (prdata != {1'b0, divisor})
               report_miss("divisor readback", prdata, {1'b0, divisor});
         end
      end
      chunks_owed = owed_chunks.size();
   end

endmodule

/* test/tb_golomb_gap_encoder_top.sv */
// Testbench top for the Golomb gap encoder: clock, reset, stimulus and verdict.
module tb_golomb_gap_encoder_top;
   import ggenc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [PADDR_W-1:0] DIVISOR_ADDR = {REG_GOLOMB_DIVISOR, 2'b00};
   localparam int unsigned IDLE_PCT        = 11;
   localparam int unsigned ITEMS_PER_PHASE = 20;
   localparam int unsigned PHASES          = 12;
   localparam int unsigned DRAIN_CYCLES    = 64;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   req_type            req_data  = '0;
   logic               rsp_ready = 1'b0;
   logic               psel      = 1'b0;
   logic               penable   = 1'b0;
   logic               pwrite    = 1'b0;
   logic [PADDR_W-1:0] paddr     = '0;
   logic [PDATA_W-1:0] pwdata    = '0;
   logic               req_ready;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic [PDATA_W-1:0] prdata;
   logic               pready;
   logic               steady    = 1'b0;
   logic [DIV_W-1:0]   cur_div   = 31'd1;
   int unsigned        miss_count;
   int unsigned        chunks_owed;

   golomb_gap_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   golomb_gap_encoder_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .miss_count  (miss_count),
      .chunks_owed (chunks_owed)
   );

   initial forever #5 clock = ~clock;

   // Run limit
   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side backpressure
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // One input beat, with random idle cycles ahead of it
   task automatic send_item(input mode_type m, input logic [31:0] v);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {m, v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Wait until every expected chunk has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (chunks_owed != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Setup and access phases, then psel and penable drop
   task automatic apb_access(input logic wr, input logic [31:0] d);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= DIVISOR_ADDR;
      pwdata  <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_divisor(input logic [31:0] d);
      drain();
      apb_access(1'b1, d);
      apb_access(1'b0, 32'd0);
      cur_div = (d[DIV_W-1:0] == 0) ? 31'd1 : d[DIV_W-1:0];
   endtask

   function automatic logic [31:0] pick_header();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 3) return 32'd0;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // Mostly well-formed gaps aimed at a chosen quotient, some past the limit
   function automatic logic [31:0] pick_gap(input logic [DIV_W-1:0] b);
      int unsigned sel;
      logic [63:0] q, r, v;
      sel = $urandom_range(0, 99);
      if (sel < 3) return 32'd0;
      if (sel < 8) return $urandom;
      if (sel < 63)      q = $urandom_range(0, 8);
      else if (sel < 85) q = $urandom_range(9, 100);
      else if (sel < 95) q = $urandom_range(101, MAX_UNARY_BITS);
      else               q = $urandom_range(MAX_UNARY_BITS + 1, MAX_UNARY_BITS + 120);
      r = (b > 1) ? 64'($urandom_range(0, b - 1)) : 64'd0;
      v = q * b + r + 1;
      if (v > 64'hFFFF_FFFF) return $urandom;
      return v[31:0];
   endfunction

   initial begin
      logic [31:0] div_plan [PHASES];
      div_plan = '{32'd1, 32'd0, 32'd2, 32'd3, 32'd5, 32'd8, 32'd100, 32'd1000,
                   32'd65537, $urandom, 32'h7FFF_FFFF, 32'hFFFF_FFFF};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // divisor after reset, headers at the value extremes
      apb_access(1'b0, 32'd0);
      send_item(MODE_HEADER, 32'd1);
      send_item(MODE_HEADER, 32'd2);
      send_item(MODE_HEADER, 32'd3);
      send_item(MODE_HEADER, 32'h8000_0000);
      send_item(MODE_HEADER, 32'hFFFF_FFFF);
      send_item(MODE_HEADER, 32'd0);
      // divisor one: unary only, longest run, one past the limit, zero gap
      send_item(MODE_GAP, 32'd1);
      send_item(MODE_GAP, 32'd2);
      send_item(MODE_GAP, MAX_UNARY_BITS + 1);
      send_item(MODE_GAP, MAX_UNARY_BITS + 2);
      send_item(MODE_GAP, 32'd0);
      send_item(MODE_GAP, 32'hFFFF_FFFF);
      // divisor zero acts as one
      write_divisor(32'd0);
      send_item(MODE_GAP, 32'd7);
      // truncated binary on both sides of the threshold
      write_divisor(32'd5);
      send_item(MODE_GAP, 32'd1);
      send_item(MODE_GAP, 32'd3);
      send_item(MODE_GAP, 32'd4);
      send_item(MODE_GAP, 32'd5);
      send_item(MODE_GAP, 32'd12);
      // widest divisor, widest tail
      write_divisor(32'h7FFF_FFFF);
      send_item(MODE_GAP, 32'd1);
      send_item(MODE_GAP, 32'h7FFF_FFFF);
      send_item(MODE_GAP, 32'h8000_0000);
      send_item(MODE_GAP, 32'hFFFF_FFFF);
      // power of two divisor
      write_divisor(32'd8);
      send_item(MODE_GAP, 32'd8);
      send_item(MODE_GAP, 32'd9);

      // random phases, one divisor each; a few phases run with no idling
      for (int p = 0; p < PHASES; p++) begin
         write_divisor(div_plan[p]);
         steady = (p >= 4 && p <= 6);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 99) < 30) send_item(MODE_HEADER, pick_header());
            else send_item(MODE_GAP, pick_gap(cur_div));
         end
      end
      steady = 1'b0;

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (miss_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
